@@ design/eth_ip_port_filter_capture_top_assert.svh @@
// assertion macros for the port filter top level
`ifndef ETH_IP_PORT_FILTER_CAPTURE_TOP_ASSERT_SVH
`define ETH_IP_PORT_FILTER_CAPTURE_TOP_ASSERT_SVH
// implication checked on every clock edge outside reset
`define EPF_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define EPF_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

@@ design/epf_pkg.sv @@
// shared types and constants of the port filter
`timescale 1ns / 1ps
`default_nettype none
package epf_pkg;
    localparam int MAX_CAPTURE = 1458;
    localparam int QDEPTH = 4;
    localparam int QAW = 2;

    typedef struct packed {
        logic         kind;
        logic [7:0]   pbyte;
        logic [63:0]  sah;
        logic [63:0]  sal;
        logic [63:0]  dah;
        logic [63:0]  dal;
        logic [15:0]  sport;
        logic [15:0]  dport;
        logic [7:0]   proto;
        logic [4:0]   flags;
        logic [10:0]  clen;
        logic         last;
    } rec_t;

    // front-to-back job: optional payload byte and optional summary
    typedef struct packed {
        logic         has_pay;
        logic         has_sum;
        logic [7:0]   pbyte;
        logic [63:0]  sah;
        logic [63:0]  sal;
        logic [63:0]  dah;
        logic [63:0]  dal;
        logic [15:0]  sport;
        logic [15:0]  dport;
        logic [7:0]   proto;
        logic [4:0]   flags;
        logic [10:0]  clen;
    } job_t;

    function automatic logic port_watched(input logic [15:0] p);
        return p == 16'd80 || p == 16'd443 || p == 16'd53 || p == 16'd445 ||
               p == 16'd389 || p == 16'd21 || p == 16'd23 || p == 16'd25 ||
               p == 16'd110 || p == 16'd143 || p == 16'd587;
    endfunction
endpackage
`default_nettype wire

@@ design/epf_parser.sv @@
// front part: frame parser and filter, emits jobs
`timescale 1ns / 1ps
`default_nettype none
module epf_parser (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    input  wire logic [7:0]     in_byte,
    input  wire logic           in_end,
    input  wire logic [10:0]    lim,
    output epf_pkg::job_t       job,
    output logic                job_valid
);
    typedef enum logic [2:0] {
        PH_ETH, PH_IPV4, PH_IPV6, PH_TRANSPORT, PH_PAYLOAD, PH_IGNORE
    } phase_t;

    phase_t       phase_reg, phase_next;
    logic [10:0]  pos_reg, pos_next;
    logic [15:0]  ek_reg, ek_next;
    logic [5:0]   ihb_reg, ihb_next;
    logic [15:0]  itl_reg, itl_next;
    logic [63:0]  sa0_reg, sa0_next, sa1_reg, sa1_next;
    logic [63:0]  da0_reg, da0_next, da1_reg, da1_next;
    logic [15:0]  p0_reg, p0_next, p1_reg, p1_next;
    logic [7:0]   pr_reg, pr_next;
    logic [4:0]   fl_reg, fl_next;
    logic [5:0]   thb_reg, thb_next;
    logic [10:0]  pc_reg, pc_next;
    logic         kept_reg, kept_next;
    logic [10:0]  r, t;
    logic         tcp;
    logic [5:0]   minlen;
    logic         pay;

    always_comb begin
        phase_next = phase_reg; ek_next = ek_reg; ihb_next = ihb_reg;
        itl_next = itl_reg; sa0_next = sa0_reg; sa1_next = sa1_reg;
        da0_next = da0_reg; da1_next = da1_reg; p0_next = p0_reg; p1_next = p1_reg;
        pr_next = pr_reg; fl_next = fl_reg; thb_next = thb_reg; pc_next = pc_reg;
        kept_next = kept_reg;
        pos_next = (pos_reg < 11'd2047) ? pos_reg + 11'd1 : pos_reg;
        r = pos_reg - 11'd14;
        t = pos_reg - 11'd14 - {5'd0, ihb_reg};
        tcp = pr_reg == 8'd6;
        minlen = tcp ? 6'd20 : 6'd8;
        pay = 1'b0;
        case (phase_reg)
            PH_ETH: begin
                if (pos_reg == 11'd12) ek_next = {in_byte, 8'd0};
                else if (pos_reg == 11'd13) begin
                    ek_next = {ek_reg[15:8], in_byte};
                    if ({ek_reg[15:8], in_byte} == 16'h0800) phase_next = PH_IPV4;
                    else if ({ek_reg[15:8], in_byte} == 16'h86DD) begin
                        ihb_next = 6'd40;
                        phase_next = PH_IPV6;
                    end else phase_next = PH_IGNORE;
                end
            end
            PH_IPV4: begin
                if (r == 11'd0) ihb_next = {in_byte[3:0], 2'b00};
                else if (r == 11'd2) itl_next = {in_byte, 8'd0};
                else if (r == 11'd3) itl_next = {itl_reg[15:8], in_byte};
                else if (r == 11'd9) pr_next = in_byte;
                else if (r >= 11'd12 && r <= 11'd15)
                    sa1_next = {32'd0, sa1_reg[23:0], in_byte};
                else if (r >= 11'd16 && r <= 11'd19)
                    da1_next = {32'd0, da1_reg[23:0], in_byte};
                if (r == 11'd19 && (ihb_reg < 6'd20 || itl_reg < {10'd0, ihb_reg}))
                    phase_next = PH_IGNORE;
                else if (r >= 11'd19 && r + 11'd1 == {5'd0, ihb_reg}) begin
                    if (pr_reg != 8'd6 && pr_reg != 8'd17) phase_next = PH_IGNORE;
                    else begin
                        thb_next = (pr_reg == 8'd17) ? 6'd8 : 6'd0;
                        phase_next = PH_TRANSPORT;
                    end
                end
            end
            PH_IPV6: begin
                if (r == 11'd6) pr_next = in_byte;
                else if (r >= 11'd8 && r <= 11'd23) begin
                    sa0_next = {sa0_reg[55:0], sa1_reg[63:56]};
                    sa1_next = {sa1_reg[55:0], in_byte};
                end else if (r >= 11'd24 && r <= 11'd39) begin
                    da0_next = {da0_reg[55:0], da1_reg[63:56]};
                    da1_next = {da1_reg[55:0], in_byte};
                end
                if (r == 11'd39) begin
                    if (pr_reg != 8'd6 && pr_reg != 8'd17) phase_next = PH_IGNORE;
                    else begin
                        thb_next = (pr_reg == 8'd17) ? 6'd8 : 6'd0;
                        phase_next = PH_TRANSPORT;
                    end
                end
            end
            PH_TRANSPORT: begin
                if (t == 11'd0) p0_next = {in_byte, 8'd0};
                else if (t == 11'd1) p0_next = {p0_reg[15:8], in_byte};
                else if (t == 11'd2) p1_next = {in_byte, 8'd0};
                else if (t == 11'd3) p1_next = {p1_reg[15:8], in_byte};
                else if (tcp && t == 11'd12) thb_next = {in_byte[7:4], 2'b00};
                else if (tcp && t == 11'd13) fl_next = in_byte[4:0];
                if (t + 11'd1 == {5'd0, minlen}) begin
                    if (!epf_pkg::port_watched(p0_reg) && !epf_pkg::port_watched(p1_reg))
                        phase_next = PH_IGNORE;
                    else if (thb_reg < minlen) phase_next = PH_IGNORE;
                    else kept_next = 1'b1;
                end
                if (phase_next == PH_TRANSPORT && kept_next &&
                    t + 11'd1 == {5'd0, thb_next})
                    phase_next = PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                if (pc_reg < lim) begin
                    pay = 1'b1;
                    pc_next = pc_reg + 11'd1;
                end
            end
            default: ;
        endcase
        job.has_pay = pay;
        job.has_sum = in_end && kept_next;
        job.pbyte = in_byte;
        job.sah = sa0_reg; job.sal = sa1_reg; job.dah = da0_reg; job.dal = da1_reg;
        job.sport = p0_reg; job.dport = p1_reg; job.proto = pr_reg;
        job.flags = fl_reg; job.clen = pc_next;
        job_valid = in_valid && (pay || (in_end && kept_next));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (in_valid && in_end)) begin
            phase_reg <= PH_ETH; pos_reg <= '0; ek_reg <= '0; ihb_reg <= '0;
            itl_reg <= '0; sa0_reg <= '0; sa1_reg <= '0; da0_reg <= '0; da1_reg <= '0;
            p0_reg <= '0; p1_reg <= '0; pr_reg <= '0; fl_reg <= '0; thb_reg <= '0;
            pc_reg <= '0; kept_reg <= 1'b0;
        end else if (in_valid) begin
            phase_reg <= phase_next; pos_reg <= pos_next; ek_reg <= ek_next;
            ihb_reg <= ihb_next; itl_reg <= itl_next; sa0_reg <= sa0_next;
            sa1_reg <= sa1_next; da0_reg <= da0_next; da1_reg <= da1_next;
            p0_reg <= p0_next; p1_reg <= p1_next; pr_reg <= pr_next; fl_reg <= fl_next;
            thb_reg <= thb_next; pc_reg <= pc_next; kept_reg <= kept_next;
        end
    end
endmodule
`default_nettype wire

@@ design/epf_queue.sv @@
// job queue between parser and emitter
`timescale 1ns / 1ps
`default_nettype none
module epf_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           wr_en,
    input  wire epf_pkg::job_t  wr_job,
    output logic                full,
    output logic                nearly_full,
    input  wire logic           rd_en,
    output epf_pkg::job_t       rd_job,
    output logic                empty
);
    epf_pkg::job_t mem [epf_pkg::QDEPTH];
    logic [epf_pkg::QAW-1:0] wp_reg, rp_reg;
    logic [epf_pkg::QAW:0]   cnt_reg;

    assign full = cnt_reg == (epf_pkg::QAW+1)'(epf_pkg::QDEPTH);
    assign nearly_full = cnt_reg >= (epf_pkg::QAW+1)'(epf_pkg::QDEPTH - 1);
    assign empty = cnt_reg == '0;
    assign rd_job = mem[rp_reg];

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wp_reg] <= wr_job;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
        end else begin
            if (wr_en) wp_reg <= wp_reg + 1'b1;
            if (rd_en) rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (epf_pkg::QAW+1)'(wr_en) - (epf_pkg::QAW+1)'(rd_en);
        end
    end
endmodule
`default_nettype wire

@@ design/epf_emitter.sv @@
// back part: turns jobs into output words
`timescale 1ns / 1ps
`default_nettype none
module epf_emitter (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire epf_pkg::job_t  job,
    input  wire logic           job_avail,
    output logic                job_pop,
    output epf_pkg::rec_t       rec,
    output logic                rec_valid,
    input  wire logic           rec_ready
);
    logic          sub_reg;
    epf_pkg::rec_t rec_reg;
    logic          v_reg;
    logic          load;
    logic          two;
    epf_pkg::rec_t nxt;

    assign two = job.has_pay && job.has_sum;
    assign load = job_avail && (!v_reg || rec_ready);
    assign job_pop = load && (!two || sub_reg);
    assign rec = rec_reg;
    assign rec_valid = v_reg;

    always_comb begin
        nxt = '0;
        if (job.has_pay && !sub_reg) begin
            nxt.pbyte = job.pbyte;
            nxt.last = !job.has_sum;
        end else begin
            nxt.kind = 1'b1;
            nxt.sah = job.sah; nxt.sal = job.sal; nxt.dah = job.dah; nxt.dal = job.dal;
            nxt.sport = job.sport; nxt.dport = job.dport; nxt.proto = job.proto;
            nxt.flags = job.flags; nxt.clen = job.clen; nxt.last = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0; sub_reg <= 1'b0;
        end else begin
            if (load) begin
                v_reg <= 1'b1;
                sub_reg <= two && !sub_reg;
            end else if (rec_ready) v_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) rec_reg <= nxt;
    end
endmodule
`default_nettype wire

@@ design/eth_ip_port_filter_capture_top.sv @@
// top level of the ethernet ip port filter with payload capture
`timescale 1ns / 1ps
`default_nettype none
// Takes one frame byte per cycle on the s_ stream and gives captured payload
// bytes and one summary word per kept frame on the m_ stream. A byte is taken
// every cycle while the four-entry job queue has room; the emitter drains one
// output word per cycle while m_tready is high, so the final payload byte and
// its summary are two output words, registered in the queue and the emitter.
`include "eth_ip_port_filter_capture_top_assert.svh"
module eth_ip_port_filter_capture_top (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           cfg_valid,
    output logic                cfg_ready,
    input  wire logic [10:0]    cfg_data,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire logic [7:0]     s_tdata,   // frame_byte
    input  wire logic           s_tlast,   // frame_end
    output logic                m_tvalid,
    input  wire logic           m_tready,
    // payload_byte, source_addr_high, source_addr_low, dest_addr_high,
    // dest_addr_low, source_port, dest_port, transport_protocol,
    // tcp_flag_bits, captured_length
    output logic [319:0]        m_tdata,
    output logic                m_tuser,   // record_kind
    output logic                m_tlast    // last_of_run
);
    logic [10:0]   lim_reg;
    logic [10:0]   lim;
    epf_pkg::job_t pjob, qjob;
    epf_pkg::rec_t rec;
    logic          jv, full, nfull, empty, pop;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) lim_reg <= 11'd1458;
        else if (cfg_valid) lim_reg <= cfg_data;
    end
    assign lim = (lim_reg > 11'(epf_pkg::MAX_CAPTURE)) ? 11'(epf_pkg::MAX_CAPTURE) : lim_reg;

    assign s_tready = !full;

    epf_parser u_parser (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_tvalid && s_tready),
        .in_byte(s_tdata), .in_end(s_tlast), .lim(lim), .job(pjob), .job_valid(jv)
    );

    epf_queue u_queue (
        .aclk(aclk), .aresetn(aresetn), .wr_en(jv), .wr_job(pjob), .full(full),
        .nearly_full(nfull), .rd_en(pop), .rd_job(qjob), .empty(empty)
    );

    epf_emitter u_emit (
        .aclk(aclk), .aresetn(aresetn), .job(qjob), .job_avail(!empty),
        .job_pop(pop), .rec(rec), .rec_valid(m_tvalid), .rec_ready(m_tready)
    );

    assign m_tuser = rec.kind;
    assign m_tlast = rec.last;
    assign m_tdata = {rec.clen, rec.flags, rec.proto, rec.dport, rec.sport,
                      rec.dal, rec.dah, rec.sal, rec.sah, rec.pbyte};

    `EPF_ASSERT_IMP(a_no_overflow, full, !jv)
    `EPF_ASSERT_IMP(a_pay_zero_meta, m_tvalid && !m_tuser, m_tdata[319:8] == '0)
    `EPF_ASSERT_NXT(a_sum_last, m_tvalid && m_tuser && !m_tready, m_tvalid && m_tlast)
    `EPF_ASSERT_IMP(a_nfull, full, nfull)
endmodule
`default_nettype wire

@@ verif/tb_top.sv @@
// testbench for the ethernet ip port filter: random and directed frames, scoreboard check
`timescale 1ns / 1ps
module tb_top;
    typedef struct {
        logic [7:0] fbyte;
        logic       fend;
    } word_t;

    typedef struct packed {
        logic         kind;
        logic [7:0]   pbyte;
        logic [63:0]  sah, sal, dah, dal;
        logic [15:0]  sport, dport;
        logic [7:0]   proto;
        logic [4:0]   flags;
        logic [10:0]  clen;
        logic         last;
    } capture_t;

    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;
    localparam logic [15:0] ETH_IPV4 = 16'h0800;
    localparam logic [15:0] ETH_IPV6 = 16'h86DD;

    typedef enum logic [2:0] {
        P_ETH, P_IPV4, P_IPV6, P_XPORT, P_PAYLOAD, P_IGNORE
    } phase_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic cfg_valid = 0;
    logic [10:0] cfg_data = 0;
    logic cfg_ready;
    logic s_tvalid = 0;
    logic [7:0] s_tdata = 0;
    logic s_tlast = 0;
    logic s_tready;
    logic m_tvalid;
    logic m_tready = 0;
    logic [319:0] m_tdata;
    logic m_tuser;
    logic m_tlast;

    eth_ip_port_filter_capture_top i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    initial forever #10 aclk = ~aclk;

    word_t frame_words[$];
    capture_t expected_caps[$];
    int errors = 0;
    bit calm = 0;
    bit stim_done = 0;

    // filter state
    logic [10:0]  lim_reg;
    logic [10:0]  pos;
    phase_t       phase;
    logic [15:0]  etype;
    logic [5:0]   iphl;
    logic [15:0]  iptl;
    logic [127:0] saddr, daddr;
    logic [15:0]  sport_r, dport_r;
    logic [7:0]   proto_r;
    logic [4:0]   flags_r;
    logic [5:0]   thl;
    logic [10:0]  pcount;
    logic         kept;

    function automatic bit listed(logic [15:0] p);
        logic [15:0] lst[11] = '{80, 443, 53, 445, 389, 21, 23, 25, 110, 143, 587};
        foreach (lst[i]) if (lst[i] == p) return 1;
        return 0;
    endfunction

    task automatic clear_frame_state();
        pos = 0; phase = P_ETH; etype = 0; iphl = 0; iptl = 0;
        saddr = 0; daddr = 0; sport_r = 0; dport_r = 0; proto_r = 0;
        flags_r = 0; thl = 0; pcount = 0; kept = 0;
    endtask

    task automatic start_transport();
        if (proto_r != PROTO_TCP && proto_r != PROTO_UDP) begin
            phase = P_IGNORE;
        end else begin
            thl = (proto_r == PROTO_UDP) ? 6'd8 : 6'd0;
            phase = P_XPORT;
        end
    endtask

    task automatic filter_byte(input logic [7:0] b, input logic fend);
        int r, t, minlen, lim, n;
        capture_t c;
        n = 0;
        lim = (lim_reg > epf_pkg::MAX_CAPTURE) ? epf_pkg::MAX_CAPTURE : lim_reg;
        case (phase)
            P_ETH: begin
                if (pos == 12) etype = {b, 8'h00};
                else if (pos == 13) begin
                    etype[7:0] = b;
                    if (etype == ETH_IPV4) phase = P_IPV4;
                    else if (etype == ETH_IPV6) begin
                        iphl = 40; phase = P_IPV6;
                    end else phase = P_IGNORE;
                end
            end
            P_IPV4: begin
                r = pos - 14;
                if (r == 0) iphl = {b[3:0], 2'b00};
                else if (r == 2) iptl = {b, 8'h00};
                else if (r == 3) iptl[7:0] = b;
                else if (r == 9) proto_r = b;
                else if (r >= 12 && r <= 15) saddr[31:0] = {saddr[23:0], b};
                else if (r >= 16 && r <= 19) daddr[31:0] = {daddr[23:0], b};
                if (r == 19 && (iphl < 20 || iptl < iphl)) phase = P_IGNORE;
                if (phase == P_IPV4 && r >= 19 && r + 1 == iphl) start_transport();
            end
            P_IPV6: begin
                r = pos - 14;
                if (r == 6) proto_r = b;
                else if (r >= 8 && r <= 23) saddr = {saddr[119:0], b};
                else if (r >= 24 && r <= 39) daddr = {daddr[119:0], b};
                if (r == 39) start_transport();
            end
            P_XPORT: begin
                t = pos - 14 - iphl;
                minlen = (proto_r == PROTO_TCP) ? 20 : 8;
                if (t == 0) sport_r = {b, 8'h00};
                else if (t == 1) sport_r[7:0] = b;
                else if (t == 2) dport_r = {b, 8'h00};
                else if (t == 3) dport_r[7:0] = b;
                else if (proto_r == PROTO_TCP && t == 12) thl = {b[7:4], 2'b00};
                else if (proto_r == PROTO_TCP && t == 13) flags_r = b[4:0];
                if (t + 1 == minlen) begin
                    if (!listed(sport_r) && !listed(dport_r)) phase = P_IGNORE;
                    else if (thl < minlen) phase = P_IGNORE;
                    else kept = 1;
                end
                if (phase == P_XPORT && kept && t + 1 == thl) phase = P_PAYLOAD;
            end
            P_PAYLOAD: begin
                if (pcount < lim) begin
                    c = '0;
                    c.pbyte = b;
                    pcount++;
                    expected_caps.push_back(c);
                    n++;
                end
            end
            default: ;
        endcase
        if (pos < 2047) pos++;
        if (fend) begin
            if (kept) begin
                c = '0;
                c.kind = 1;
                c.sah = saddr[127:64]; c.sal = saddr[63:0];
                c.dah = daddr[127:64]; c.dal = daddr[63:0];
                c.sport = sport_r; c.dport = dport_r;
                c.proto = proto_r; c.flags = flags_r; c.clen = pcount;
                expected_caps.push_back(c);
                n++;
            end
            clear_frame_state();
        end
        if (n > 0) expected_caps[$].last = 1;
    endtask

    // stimulus generation
    function automatic logic [15:0] pick_port();
        logic [15:0] lst[11] = '{80, 443, 53, 445, 389, 21, 23, 25, 110, 143, 587};
        case ($urandom_range(0, 3))
            0, 1: return lst[$urandom_range(0, 10)];
            2: return 16'($urandom);
            default: return 16'($urandom_range(0, 600));
        endcase
    endfunction

    // style: 0 good, 1 broken header/cut short, 2 random noise
    task automatic build_frame(input bit v6, input bit tcp, input int paylen,
                               input int style, input int ihl_sel, input int doff_sel);
        logic [7:0] f[$];
        int ihl, doff, cut, tl;
        logic [15:0] sp, dp;
        if (style == 2) begin
            repeat ($urandom_range(1, 40)) f.push_back(8'($urandom));
        end else begin
            repeat (12) f.push_back(8'($urandom));
            if (v6) begin
                f.push_back(8'h86); f.push_back(8'hDD);
                f.push_back(8'($urandom)); repeat (3) f.push_back(8'($urandom));
                f.push_back(8'($urandom)); f.push_back(8'($urandom));
                f.push_back(tcp ? PROTO_TCP : (style == 1 && $urandom_range(0, 2) == 0) ?
                            8'($urandom) : PROTO_UDP);
                f.push_back(8'($urandom));
                repeat (32) f.push_back(8'($urandom));
            end else begin
                f.push_back(8'h08); f.push_back(8'h00);
                ihl = (ihl_sel >= 0) ? ihl_sel : $urandom_range(5, 7);
                f.push_back({4'h4, 4'(ihl)} ^ {($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'h0,
                            4'h0});
                f.push_back(8'($urandom));
                tl = (style == 1 && $urandom_range(0, 1)) ? $urandom_range(0, 40) :
                     $urandom_range(ihl * 4, 65535);
                f.push_back(8'(tl >> 8)); f.push_back(8'(tl));
                repeat (5) f.push_back(8'($urandom));
                f.push_back(tcp ? PROTO_TCP : PROTO_UDP);
                repeat (2) f.push_back(8'($urandom));
                repeat (8) f.push_back(8'($urandom));
                repeat ((ihl > 5 ? ihl - 5 : 0) * 4) f.push_back(8'($urandom));
            end
            sp = pick_port(); dp = pick_port();
            f.push_back(sp[15:8]); f.push_back(sp[7:0]);
            f.push_back(dp[15:8]); f.push_back(dp[7:0]);
            if (tcp) begin
                doff = (doff_sel >= 0) ? doff_sel : $urandom_range(5, 8);
                repeat (8) f.push_back(8'($urandom));
                f.push_back({4'(doff), 4'($urandom)});
                f.push_back(8'($urandom));
                repeat (6) f.push_back(8'($urandom));
                repeat ((doff > 5 ? doff - 5 : 0) * 4) f.push_back(8'($urandom));
            end else begin
                repeat (4) f.push_back(8'($urandom));
            end
            repeat (paylen) f.push_back(8'($urandom));
            if (style == 1) begin
                cut = $urandom_range(1, f.size());
                while (f.size() > cut) void'(f.pop_back());
            end
        end
        foreach (f[i]) frame_words.push_back('{f[i], i == f.size() - 1});
    endtask

    task automatic wait_idle();
        while (frame_words.size() != 0 || expected_caps.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [10:0] v);
        cfg_valid <= 1; cfg_data <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        lim_reg = v;
        cfg_valid <= 0;
    endtask

    // driver
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                filter_byte(s_tdata, s_tlast);
                void'(frame_words.pop_front());
            end
            if (frame_words.size() != 0 &&
                (calm || $urandom_range(0, 99) >= 33 || (s_tvalid && !s_tready))) begin
                if (!(s_tvalid && !s_tready)) begin
                    s_tdata <= (s_tvalid && s_tready) ? frame_words[0].fbyte :
                               frame_words[0].fbyte;
                    s_tlast <= frame_words[0].fend;
                end
                s_tvalid <= 1;
            end else begin
                s_tvalid <= 0;
            end
            m_tready <= calm || $urandom_range(0, 99) >= 33;
        end
    end

    // monitor
    always @(posedge aclk) begin
        capture_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.kind = m_tuser; got.last = m_tlast;
            {got.clen, got.flags, got.proto, got.dport, got.sport, got.dal, got.dah,
             got.sal, got.sah, got.pbyte} = m_tdata;
            if (expected_caps.size() == 0) begin
                $display("%0t unexpected word %p", $time, got);
                errors++;
            end else begin
                want = expected_caps.pop_front();
                if (got != want) begin
                    $display("%0t mismatch expected %p actual %p", $time, want, got);
                    errors++;
                end
            end
        end
    end

    initial begin
        int lims[6] = '{1458, 0, 1, 5, 2047, 1457};
        lim_reg = 1458;
        clear_frame_state();
        repeat (6) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        // directed
        calm = 1;
        build_frame(0, 1, 10, 0, 5, 5);
        build_frame(0, 0, 3, 0, 15, -1);
        build_frame(1, 1, 4, 0, -1, 15);
        build_frame(1, 0, 0, 0, -1, -1);
        build_frame(0, 1, 6, 0, 4, 5);
        build_frame(0, 1, 6, 0, 5, 4);
        build_frame(0, 1, 0, 0, 5, 8);
        build_frame(0, 0, 0, 0, 5, -1);
        build_frame(1, 1, 3, 1, -1, -1);
        build_frame(0, 0, 2, 2, -1, -1);
        frame_words.push_back('{8'hFF, 1});
        frame_words.push_back('{8'h00, 1});
        wait_idle();
        calm = 0;
        for (int ph = 0; ph < 6; ph++) begin
            write_limit(11'(lims[ph]));
            for (int k = 0; k < 3; k++) begin
                int sty;
                sty = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 2);
                build_frame($urandom_range(0, 1), $urandom_range(0, 1),
                            $urandom_range(0, 20), sty, -1, -1);
            end
            if (ph == 2) calm = 1;
            if (ph == 3) calm = 0;
            wait_idle();
        end
        if (errors == 0) begin
            $display("PASS eth_ip_port_filter_capture_top");
        end else begin
            $display("FAIL eth_ip_port_filter_capture_top");
        end
        $finish;
    end

    initial begin
        #50ms;
        $display("FAIL eth_ip_port_filter_capture_top");
        $finish;
    end
endmodule
